// ----- rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the priority track table: transaction
// payloads, status codes, the packet that walks the slot chain and the
// commit commands broadcast to every slot.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STOP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_STOPPED  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    PASS_SCAN  = 1'b0,
    PASS_CLAIM = 1'b1
  } pass_mode_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] track_code;
    logic [7:0] track_priority;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic       selection_changed;
    logic       playing;
    logic [7:0] playing_code;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    pass_mode_t mode;
    logic [7:0] code;
    logic [7:0] prio;
    logic       match;
    logic       match_cur;
    logic       free;
    logic [7:0] top_prio;
    logic [7:0] best_code;
  } scan_pkt_t;

  typedef struct packed {
    logic       write_new;
    logic       select_new;
    logic       clear_hit;
    logic       clear_cur;
    logic [7:0] code;
    logic [7:0] prio;
  } cell_cmd_t;

endpackage

// ----- rtl/ptt_cell.sv -----
// ----------------------------------------------------------------------------
// ptt_cell
// One table slot: holds a code, a priority and the current-selection flag,
// updates the packet passing down the chain and applies commit commands.
// ----------------------------------------------------------------------------
module ptt_cell
  import ptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_pkt_t pkt_in,
  output scan_pkt_t pkt_out,
  input  cell_cmd_t cmd
);

  logic [7:0] code_r;
  logic [7:0] prio_r;
  logic       cur_r;
  logic       hit_sel_r;
  logic       free_sel_r;
  scan_pkt_t  pkt_r;
  scan_pkt_t  pkt_nxt;

  logic       is_scan;
  logic       hit;
  logic       is_free;
  logic       first_hit;
  logic       first_free;
  logic [7:0] eff_prio;
  logic       claim_hit;

  assign is_scan    = pkt_in.valid && (pkt_in.mode == PASS_SCAN);
  assign hit        = (code_r == pkt_in.code) && (prio_r == pkt_in.prio);
  assign is_free    = (code_r == 8'd0) && (prio_r == 8'd0);
  assign first_hit  = hit && !pkt_in.match;
  assign first_free = is_free && !pkt_in.free;
  assign eff_prio   = first_hit ? 8'd0 : prio_r;
  assign claim_hit  = pkt_in.valid && (pkt_in.mode == PASS_CLAIM) && !pkt_in.match &&
                      !hit_sel_r && (prio_r == pkt_in.top_prio);

  always_comb begin
    pkt_nxt = pkt_in;
    if (pkt_in.mode == PASS_SCAN) begin
      pkt_nxt.match     = pkt_in.match | hit;
      pkt_nxt.match_cur = pkt_in.match_cur | (first_hit & cur_r);
      pkt_nxt.free      = pkt_in.free | is_free;
      if (eff_prio > pkt_in.top_prio) begin
        pkt_nxt.top_prio  = eff_prio;
        pkt_nxt.best_code = code_r;
      end
    end else begin
      pkt_nxt.match = pkt_in.match | claim_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r     <= 8'd0;
      prio_r     <= 8'd0;
      cur_r      <= 1'b0;
      hit_sel_r  <= 1'b0;
      free_sel_r <= 1'b0;
      pkt_r      <= '0;
    end else begin
      pkt_r <= pkt_nxt;
      if (is_scan) begin
        hit_sel_r  <= first_hit;
        free_sel_r <= first_free;
      end
      if (cmd.write_new && free_sel_r) begin
        code_r <= cmd.code;
        prio_r <= cmd.prio;
      end else if (cmd.clear_hit && hit_sel_r) begin
        code_r <= 8'd0;
        prio_r <= 8'd0;
      end
      if (cmd.clear_cur) begin
        cur_r <= 1'b0;
      end
      if (cmd.select_new) begin
        cur_r <= free_sel_r;
      end
      if (claim_hit) begin
        cur_r <= 1'b1;
      end
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ----- rtl/ptt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: launches scan and claim passes down the slot chain, decides
// each transaction from the returning packet and holds the selection copy.
// ----------------------------------------------------------------------------
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  output scan_pkt_t pkt_out,
  input  scan_pkt_t pkt_in,
  output cell_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLAIM
  } state_t;

  state_t     state_r;
  in_item_t   req_r;
  out_item_t  out_r;
  logic       out_valid_r;
  scan_pkt_t  pkt_r;
  cell_cmd_t  cmd_r;
  logic       cur_valid_r;
  logic [7:0] cur_prio_r;
  logic [7:0] cur_code_r;

  out_item_t  out_nxt;
  scan_pkt_t  scan_launch;
  scan_pkt_t  claim_launch;
  logic       write_new;
  logic       select_new;
  logic       clear_hit;
  logic       rescan;

  always_comb begin
    scan_launch       = '0;
    scan_launch.valid = 1'b1;
    scan_launch.mode  = PASS_SCAN;
    scan_launch.code  = in_data.track_code;
    scan_launch.prio  = in_data.track_priority;

    claim_launch          = '0;
    claim_launch.valid    = 1'b1;
    claim_launch.mode     = PASS_CLAIM;
    claim_launch.top_prio = pkt_in.top_prio;
  end

  always_comb begin
    out_nxt.status            = ST_QUEUED;
    out_nxt.selection_changed = 1'b0;
    out_nxt.playing           = cur_valid_r;
    out_nxt.playing_code      = cur_code_r;
    write_new                 = 1'b0;
    select_new                = 1'b0;
    clear_hit                 = 1'b0;
    rescan                    = 1'b0;
    if (req_r.op == OP_START) begin
      if (pkt_in.match) begin
        out_nxt.status = ST_QUEUED;
      end else if (!pkt_in.free) begin
        out_nxt.status = ST_FULL;
      end else begin
        out_nxt.status = ST_STARTED;
        write_new      = 1'b1;
        if (!cur_valid_r || (cur_prio_r < req_r.track_priority)) begin
          select_new                = 1'b1;
          out_nxt.selection_changed = 1'b1;
          out_nxt.playing           = 1'b1;
          out_nxt.playing_code      = req_r.track_code;
        end
      end
    end else begin
      if (!pkt_in.match) begin
        out_nxt.status = ST_NOTFOUND;
      end else begin
        out_nxt.status = ST_STOPPED;
        clear_hit      = 1'b1;
        if (pkt_in.match_cur) begin
          rescan                    = 1'b1;
          out_nxt.selection_changed = 1'b1;
          out_nxt.playing           = (pkt_in.top_prio != 8'd0);
          out_nxt.playing_code      = (pkt_in.top_prio != 8'd0) ? pkt_in.best_code : 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pkt_r       <= '0;
      cmd_r       <= '0;
      cur_valid_r <= 1'b0;
      cur_prio_r  <= 8'd0;
      cur_code_r  <= 8'd0;
    end else begin
      out_valid_r <= 1'b0;
      pkt_r.valid <= 1'b0;
      cmd_r       <= '0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= in_data;
            pkt_r   <= scan_launch;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pkt_in.valid) begin
            out_r            <= out_nxt;
            cmd_r.write_new  <= write_new;
            cmd_r.select_new <= select_new;
            cmd_r.clear_hit  <= clear_hit;
            cmd_r.clear_cur  <= rescan;
            cmd_r.code       <= req_r.track_code;
            cmd_r.prio       <= req_r.track_priority;
            if (select_new) begin
              cur_valid_r <= 1'b1;
              cur_prio_r  <= req_r.track_priority;
              cur_code_r  <= req_r.track_code;
            end
            if (rescan) begin
              cur_valid_r <= out_nxt.playing;
              cur_prio_r  <= pkt_in.top_prio;
              cur_code_r  <= out_nxt.playing_code;
            end
            if (rescan && out_nxt.playing) begin
              pkt_r   <= claim_launch;
              state_r <= S_CLAIM;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_CLAIM: begin
          if (pkt_in.valid) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pkt_out   = pkt_r;
  assign cmd       = cmd_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_off_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.playing) |-> (out_data.playing_code == 8'd0))
    else $error("nonzero code while nothing playing");

  a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_in.valid |-> busy)
    else $error("packet returned from chain while idle");

  a_changed_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.selection_changed) |->
      (out_data.status == ST_STARTED || out_data.status == ST_STOPPED))
    else $error("selection changed on refused transaction");
`endif

endmodule

// ----- rtl/priority_track_table_core.sv -----
// ----------------------------------------------------------------------------
// priority_track_table_core
// Table of track requests with priority selection, built as a chain of
// slot cells walked by a packet from a central sequencer.
// ----------------------------------------------------------------------------
//  channel  | ports                   | handshake
//  ---------+-------------------------+------------------------------------
//  input    | start, busy, in_data    | taken at an edge with start & !busy
//  result   | out_valid, out_data     | one-cycle strobe, cannot be stalled
//
//  A transaction sends one scan packet down the chain and back to the
//  sequencer; the packet moves one slot per cycle.
//  A stop that frees the playing slot and finds another track runs a second
//  pass to mark the winner.
//  Synchronous reset clears all slots and the selection.
//  busy stays high from accept until the result strobe.
// ----------------------------------------------------------------------------
module priority_track_table_core
  import ptt_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  scan_pkt_t chain [NUM_SLOTS+1];
  cell_cmd_t cmd;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .pkt_out   (chain[0]),
    .pkt_in    (chain[NUM_SLOTS]),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    ptt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .pkt_in  (chain[i]),
      .pkt_out (chain[i+1]),
      .cmd     (cmd)
    );
  end

endmodule
